### src/wsfb_pkg.sv
package wsfb_pkg;

    localparam int LENGTH_BITS_DEF = 64;
    localparam int HDR_MAX         = 14;
    localparam int HDR_CNT_W       = $clog2(HDR_MAX + 1);

    localparam logic       KIND_HEADER = 1'b0;
    localparam logic       KIND_DATA   = 1'b1;

    localparam logic [7:0] FIN_BIT     = 8'h80;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [7:0] LEN_16_CODE = 8'd126;
    localparam logic [7:0] LEN_64_CODE = 8'd127;
    localparam logic [63:0] LEN_7_LIMIT  = 64'd126;
    localparam logic [63:0] LEN_16_LIMIT = 64'd65536;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic        kind;
        logic [3:0]  frame_opcode;
        logic        final_flag;
        logic        use_mask;
        logic [31:0] key_word;
        logic [63:0] payload_length;
        logic [63:0] out_capacity;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
        logic       too_big;
    } t_out;

endpackage

### src/wsfb_stream_if.sv
interface wsfb_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/websocket_frame_builder.sv
// Channel  | Dir | Beat
// ---------+-----+------------------------------------------------------
// i_frm    | in  | header command (kind 0) or payload byte (kind 1)
// o_frm    | out | one frame byte with run/frame end marks, or an error
//
// While o_frm is not stalled, payload beats pass at one per cycle, input
// register then result register, and a header beat loads a 14-byte shift
// buffer that drains one byte per cycle; no beat is taken while it drains.
// Reset (i_rst_n low, synchronous) empties both registers and closes any frame.
// A stalled o_frm holds its beat; i_frm keeps taking beats while the
// result register or header buffer has room to move.
module websocket_frame_builder #(
    parameter int LENGTH_BITS = wsfb_pkg::LENGTH_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wsfb_stream_if.sink   i_frm,
    wsfb_stream_if.source o_frm
);
    import wsfb_pkg::*;

    logic                   r_in_vld;
    t_in                    r_in;
    logic                   r_out_vld;
    t_out                   r_out;
    t_byte                  r_hdr [HDR_MAX];
    logic [HDR_CNT_W-1:0]   r_hdr_cnt;
    logic                   r_hdr_fl;
    logic                   r_hdr_err;
    logic [LENGTH_BITS-1:0] r_rem;
    logic [1:0]             r_phase;
    logic [31:0]            r_key;
    logic                   r_mask_on;
    logic                   r_open;

    logic                   out_free;
    logic                   hdr_busy;
    logic                   hdr_emit;
    logic                   take_hdr;
    logic                   take_data;
    logic                   data_emit;
    logic                   in_take;
    logic [63:0]            len64;
    logic [3:0]             base;
    logic [64:0]            total;
    logic                   err;
    t_byte                  n_hdr [HDR_MAX];
    logic [HDR_CNT_W-1:0]   n_hdr_cnt;
    t_byte                  key_byte;
    logic [LENGTH_BITS-1:0] n_rem;
    t_out                   n_out;

    always_comb begin
        out_free  = !r_out_vld || o_frm.ready;
        hdr_busy  = r_hdr_cnt != '0;
        hdr_emit  = hdr_busy && out_free;
        take_hdr  = r_in_vld && !hdr_busy && (r_in.kind == KIND_HEADER);
        take_data = r_in_vld && !hdr_busy && (r_in.kind == KIND_DATA)
                    && (!r_open || out_free);
        data_emit = take_data && r_open;
        in_take   = take_hdr || take_data;
    end

    assign i_frm.ready = !r_in_vld || in_take;
    assign o_frm.valid = r_out_vld;
    assign o_frm.data  = r_out;

    // header build
    always_comb begin
        len64 = 64'(r_in.payload_length[LENGTH_BITS-1:0]);
        base  = 4'd2;
        if (len64 >= LEN_16_LIMIT) begin
            base = 4'd10;
        end else if (len64 >= LEN_7_LIMIT) begin
            base = 4'd4;
        end
        if (r_in.use_mask) begin
            base = base + 4'd4;
        end
        total = {1'b0, len64} + 65'(base);
        err   = total > {1'b0, r_in.out_capacity};

        for (int i = 0; i < HDR_MAX; i++) begin
            n_hdr[i] = '0;
        end
        n_hdr[0] = (r_in.final_flag ? FIN_BIT : 8'h00) | {4'h0, r_in.frame_opcode};
        if (len64 < LEN_7_LIMIT) begin
            n_hdr[1] = (r_in.use_mask ? MASK_BIT : 8'h00) | {1'b0, len64[6:0]};
            for (int k = 0; k < 4; k++) begin
                n_hdr[2 + k] = r_in.key_word[31 - 8 * k -: 8];
            end
        end else if (len64 < LEN_16_LIMIT) begin
            n_hdr[1] = (r_in.use_mask ? MASK_BIT : 8'h00) | LEN_16_CODE;
            n_hdr[2] = len64[15:8];
            n_hdr[3] = len64[7:0];
            for (int k = 0; k < 4; k++) begin
                n_hdr[4 + k] = r_in.key_word[31 - 8 * k -: 8];
            end
        end else begin
            n_hdr[1] = (r_in.use_mask ? MASK_BIT : 8'h00) | LEN_64_CODE;
            for (int b = 0; b < 8; b++) begin
                n_hdr[2 + b] = len64[63 - 8 * b -: 8];
            end
            for (int k = 0; k < 4; k++) begin
                n_hdr[10 + k] = r_in.key_word[31 - 8 * k -: 8];
            end
        end
        n_hdr_cnt = HDR_CNT_W'(base);
        if (err) begin
            n_hdr[0]  = '0;
            n_hdr_cnt = HDR_CNT_W'(1);
        end
    end

    // payload path and output beat select
    always_comb begin
        case (r_phase)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        n_rem = r_rem - LENGTH_BITS'(1);

        n_out = '0;
        if (hdr_emit) begin
            n_out.out_byte   = r_hdr[0];
            n_out.run_last   = r_hdr_cnt == HDR_CNT_W'(1);
            n_out.frame_last = (r_hdr_cnt == HDR_CNT_W'(1)) && r_hdr_fl;
            n_out.too_big    = r_hdr_err;
        end else begin
            n_out.out_byte   = r_in.data_byte ^ (r_mask_on ? key_byte : 8'h00);
            n_out.run_last   = 1'b1;
            n_out.frame_last = n_rem == '0;
            n_out.too_big    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_hdr_cnt <= '0;
            r_open    <= 1'b0;
            r_phase   <= '0;
            r_rem     <= '0;
            r_key     <= '0;
            r_mask_on <= 1'b0;
            r_hdr_fl  <= 1'b0;
            r_hdr_err <= 1'b0;
        end else begin
            if (i_frm.ready) begin
                r_in_vld <= i_frm.valid;
            end
            if (out_free) begin
                r_out_vld <= hdr_emit || data_emit;
            end
            if (take_hdr) begin
                r_hdr_cnt <= n_hdr_cnt;
                r_hdr_fl  <= !err && (len64 == '0);
                r_hdr_err <= err;
                r_open    <= !err && (len64 != '0);
                r_phase   <= '0;
                r_rem     <= r_in.payload_length[LENGTH_BITS-1:0];
                r_key     <= r_in.key_word;
                r_mask_on <= r_in.use_mask;
            end else if (hdr_emit) begin
                r_hdr_cnt <= r_hdr_cnt - HDR_CNT_W'(1);
            end
            if (data_emit) begin
                r_phase <= r_phase + 2'd1;
                r_rem   <= n_rem;
                r_open  <= n_rem != '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frm.ready) begin
            r_in <= i_frm.data;
        end
        if (out_free) begin
            r_out <= n_out;
        end
        if (take_hdr) begin
            r_hdr <= n_hdr;
        end else if (hdr_emit) begin
            for (int i = 0; i < HDR_MAX - 1; i++) begin
                r_hdr[i] <= r_hdr[i + 1];
            end
            r_hdr[HDR_MAX-1] <= '0;
        end
    end

    a_hdr_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= HDR_CNT_W'(HDR_MAX))
        else $error("header byte count out of range");

    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> r_rem != '0)
        else $error("frame open with no bytes left");

    a_no_take_while_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hdr_busy |-> !in_take)
        else $error("input consumed while header drains");

    a_err_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.too_big) |-> (r_out.run_last && !r_out.frame_last))
        else $error("error beat marks wrong");

endmodule

### verif/wsfb_frame_checker.sv
module wsfb_frame_checker #(
    parameter int LENGTH_BITS = wsfb_pkg::LENGTH_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  wsfb_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  wsfb_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import wsfb_pkg::*;

    localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

    logic [63:0] bytes_left;
    logic [1:0]  key_phase_q;
    logic [31:0] frame_key;
    logic        mask_q;
    logic        frame_open_q;
    t_out        frame_bytes_q[$];
    int          fail_count = 0;

    function automatic t_out frame_byte(t_byte b, logic rl, logic fl, logic tb);
        t_out r;
        r.out_byte   = b;
        r.run_last   = rl;
        r.frame_last = fl;
        r.too_big    = tb;
        return r;
    endfunction

    task automatic encode_beat(input t_in beat);
        t_byte       hdr[HDR_MAX];
        int          n;
        logic [63:0] len;
        logic [63:0] hdr_size;
        t_byte       b;
        n = 0;
        if (beat.kind == KIND_DATA) begin
            if (!frame_open_q) return;
            b = beat.data_byte;
            if (mask_q) b ^= frame_key[8 * (3 - key_phase_q) +: 8];
            key_phase_q = key_phase_q + 2'd1;
            bytes_left  = bytes_left - 64'd1;
            if (bytes_left == 64'd0) frame_open_q = 1'b0;
            frame_bytes_q.push_back(frame_byte(b, 1'b1, bytes_left == 64'd0, 1'b0));
            return;
        end

        // a new header always drops whatever frame was open
        frame_open_q = 1'b0;
        len = beat.payload_length & LEN_MASK;
        hdr_size = 64'd2 + ((len >= LEN_16_LIMIT) ? 64'd8 : (len >= LEN_7_LIMIT) ? 64'd2 : 64'd0)
                 + (beat.use_mask ? 64'd4 : 64'd0);
        if (len > ~64'd0 - hdr_size || beat.out_capacity < hdr_size + len) begin
            frame_bytes_q.push_back(frame_byte(8'h00, 1'b1, 1'b0, 1'b1));
            return;
        end

        hdr[n] = (beat.final_flag ? FIN_BIT : 8'h00) | {4'h0, beat.frame_opcode};
        n++;
        if (len < LEN_7_LIMIT) begin
            hdr[n] = {beat.use_mask, len[6:0]};
            n++;
        end else if (len < LEN_16_LIMIT) begin
            hdr[n] = (beat.use_mask ? MASK_BIT : 8'h00) | LEN_16_CODE;
            hdr[n + 1] = len[15:8];
            hdr[n + 2] = len[7:0];
            n += 3;
        end else begin
            hdr[n] = (beat.use_mask ? MASK_BIT : 8'h00) | LEN_64_CODE;
            n++;
            for (int i = 7; i >= 0; i--) begin
                hdr[n] = len[8 * i +: 8];
                n++;
            end
        end
        if (beat.use_mask) begin
            for (int i = 3; i >= 0; i--) begin
                hdr[n] = beat.key_word[8 * i +: 8];
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            frame_bytes_q.push_back(frame_byte(hdr[i], i == n - 1,
                                               (i == n - 1) && (len == 64'd0), 1'b0));
        end

        frame_key    = beat.key_word;
        mask_q       = beat.use_mask;
        key_phase_q  = 2'd0;
        bytes_left   = len;
        frame_open_q = (len != 64'd0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            bytes_left   = '0;
            key_phase_q  = '0;
            frame_key    = '0;
            mask_q       = 1'b0;
            frame_open_q = 1'b0;
            frame_bytes_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) encode_beat(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (frame_bytes_q.size() == 0) begin
                    $error("unexpected beat: out_byte %0h run_last %0b frame_last %0b too_big %0b",
                           i_out_data.out_byte, i_out_data.run_last, i_out_data.frame_last,
                           i_out_data.too_big);
                    fail_count++;
                end else begin
                    want = frame_bytes_q.pop_front();
                    check_field("out_byte", want.out_byte, i_out_data.out_byte);
                    check_field("run_last", 8'(want.run_last), 8'(i_out_data.run_last));
                    check_field("frame_last", 8'(want.frame_last), 8'(i_out_data.frame_last));
                    check_field("too_big", 8'(want.too_big), 8'(i_out_data.too_big));
                end
            end
        end
        o_pending    <= frame_bytes_q.size();
        o_fail_count <= fail_count;
    end

endmodule

### verif/tb_websocket_frame_builder.sv
module tb_websocket_frame_builder;
    timeunit 1ns;
    timeprecision 1ps;
    import wsfb_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 310;
    localparam int QUIET_FROM   = 240;
    localparam int END_CYCLES   = 40;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_bytes;
    int   items_sent  = 0;
    int   idle_cycles = 0;
    bit   bubbles_on  = 1'b1;
    bit   long_hold   = 1'b0;

    wsfb_stream_if #(.t_data(t_in))  frm_in_if ();
    wsfb_stream_if #(.t_data(t_out)) frm_out_if ();

    websocket_frame_builder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_frm   (frm_in_if),
        .o_frm   (frm_out_if)
    );

    wsfb_frame_checker u_frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (frm_in_if.valid),
        .i_in_ready   (frm_in_if.ready),
        .i_in_data    (frm_in_if.data),
        .i_out_valid  (frm_out_if.valid),
        .i_out_ready  (frm_out_if.ready),
        .i_out_data   (frm_out_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending_bytes)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (frm_in_if.valid && frm_in_if.ready)
                   || (frm_out_if.valid && frm_out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sink side: random backpressure, plus one long hold on request
    initial begin
        frm_out_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (long_hold) begin
                frm_out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else if (bubbles_on && $urandom_range(0, 2) == 0) begin
                frm_out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            frm_out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    function automatic t_in random_beat();
        t_in r;
        r.kind           = 1'($urandom_range(0, 1));
        r.frame_opcode   = 4'($urandom_range(0, 15));
        r.final_flag     = 1'($urandom_range(0, 1));
        r.use_mask       = 1'($urandom_range(0, 1));
        r.key_word       = $urandom;
        r.payload_length = {$urandom, $urandom};
        r.out_capacity   = {$urandom, $urandom};
        r.data_byte      = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic logic [63:0] frame_size(logic [63:0] len, logic msk);
        return 64'd2 + ((len >= LEN_16_LIMIT) ? 64'd8 : (len >= LEN_7_LIMIT) ? 64'd2 : 64'd0)
             + (msk ? 64'd4 : 64'd0) + len;
    endfunction

    task automatic send_beat(input t_in beat);
        if (bubbles_on && $urandom_range(0, 3) == 0) begin
            frm_in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        frm_in_if.valid <= 1'b1;
        frm_in_if.data  <= beat;
        do @(posedge clk); while (!(frm_in_if.valid && frm_in_if.ready));
    endtask

    task automatic send_header(input logic fin, input logic [3:0] opc, input logic msk,
                               input logic [31:0] key, input logic [63:0] len,
                               input logic [63:0] cap);
        t_in b;
        b = random_beat();
        b.kind           = KIND_HEADER;
        b.final_flag     = fin;
        b.frame_opcode   = opc;
        b.use_mask       = msk;
        b.key_word       = key;
        b.payload_length = len;
        b.out_capacity   = cap;
        send_beat(b);
    endtask

    task automatic send_payload(input t_byte d);
        t_in b;
        b = random_beat();
        b.kind      = KIND_DATA;
        b.data_byte = d;
        send_beat(b);
    endtask

    task automatic send_frame(input logic [63:0] len, input int beats, input bit short_cap);
        logic        msk;
        logic [63:0] cap;
        msk = 1'($urandom_range(0, 1));
        cap = short_cap ? frame_size(len, msk) - 64'd1
                        : frame_size(len, msk) + 64'($urandom_range(0, 3));
        send_header(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), msk, $urandom,
                    len, cap);
        repeat (beats) send_payload(8'($urandom_range(0, 255)));
        items_sent += short_cap ? 1 : 1 + beats;
    endtask

    task automatic wait_frames_drained();
        frm_in_if.valid <= 1'b0;
        do @(posedge clk); while (pending_bytes != 0);
    endtask

    initial begin
        int          sel;
        int          beats;
        logic [63:0] len;
        t_in         b;

        rst_n           <= 1'b0;
        frm_in_if.valid <= 1'b0;
        frm_in_if.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_payload(8'h5A);                                  // no frame open
        send_header(1'b1, 4'hF, 1'b0, 32'h0, 64'd0, 64'd2);   // empty frame, exact fit
        send_header(1'b0, 4'h0, 1'b0, 32'h0, 64'd0, 64'd1);   // too big
        send_header(1'b1, 4'h2, 1'b1, 32'hFFFF_FFFF, 64'd3, 64'd9);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'hA5);
        send_payload(8'h11);                                  // frame already closed
        send_header(1'b0, 4'h1, 1'b0, 32'h0, 64'd125, 64'd127);
        send_payload(8'h3C);                                  // left open, next header drops it
        send_header(1'b1, 4'h8, 1'b1, 32'h8040_2010, 64'd126, 64'd133);
        send_header(1'b1, 4'h2, 1'b0, $urandom, 64'd126, ALL_ONES);
        send_payload(8'h7E);
        send_header(1'b1, 4'h2, 1'b1, 32'h0123_4567, 64'd65535, ALL_ONES);
        send_header(1'b0, 4'h9, 1'b1, 32'hDEAD_BEEF, 64'd65536, ALL_ONES);
        send_payload(8'h01);
        send_payload(8'h80);
        send_header(1'b1, 4'hA, 1'b0, 32'h0, ALL_ONES, ALL_ONES);         // size wraps
        send_header(1'b1, 4'h1, 1'b1, 32'h0, ALL_ONES - 64'd14, ALL_ONES); // just fits
        send_payload(8'hC3);
        send_header(1'b1, 4'h1, 1'b1, 32'h0, ALL_ONES - 64'd13, ALL_ONES); // just wraps
        send_header(1'b1, 4'h0, 1'b1, 32'hA5A5_5A5A, 64'd5, 64'd11);
        repeat (5) send_payload(8'($urandom_range(0, 255)));
        wait_frames_drained();

        // sink holds off while a long frame keeps coming
        long_hold = 1'b1;
        send_frame(64'd60, 60, 1'b0);
        wait_frames_drained();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= QUIET_FROM) bubbles_on = 1'b0;
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
                sel = $urandom_range(0, 9);
                if (sel < 7) len = 64'($urandom_range(0, 20));
                else if (sel < 9) len = 64'($urandom_range(120, 200));
                else len = 64'($urandom_range(65530, 65600));
                beats = (len > 200) ? $urandom_range(0, 40) : int'(len);
                if ($urandom_range(0, 7) == 0) beats = $urandom_range(0, beats);
                send_frame(len, beats, 1'b0);
            end else if (sel == 6) begin
                b = random_beat();
                b.kind = KIND_HEADER;
                send_beat(b);
                items_sent++;
            end else if (sel == 7) begin
                beats = $urandom_range(1, 3);
                repeat (beats) send_payload(8'($urandom_range(0, 255)));
                items_sent += beats;
            end else if (sel == 8) begin
                len = {1'b1, 31'($urandom), $urandom} >> $urandom_range(0, 47);
                send_header(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), $urandom, len, ALL_ONES);
                beats = $urandom_range(0, 10);
                repeat (beats) send_payload(8'($urandom_range(0, 255)));
                items_sent += 1 + beats;
            end else begin
                send_frame(64'($urandom_range(0, 300)), 0, 1'b1);
            end
            if ($urandom_range(0, 40) == 0) wait_frames_drained();
        end

        wait_frames_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
